>>> design/button_debounce_press_classifier_defines.svh
// Assertion macros shared by the button press classifier RTL.
// Depends on nothing; every user must have clk and arst_n in scope.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`ifndef ASSERT_OFF
`define BDPC_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");
`define BDPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check violated");
`else
`define BDPC_ASSERT_ALWAYS(lbl, expr)
`define BDPC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/bdpc_pkg.sv
// Shared types and constants for the button debounce press classifier.
// Depends on nothing.
package bdpc_pkg;

	localparam int HOLD_W = 16;
	localparam int SAMPLE_W = 4;
	localparam int POLL_W = 16;
	localparam int CMP_W = (HOLD_W > POLL_W) ? HOLD_W : POLL_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_STABLE_POLLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_POLLS = 1'd1;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG_START = 2'd2,
		EV_LONG_END = 2'd3
	} event_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] stable_polls;
		logic [POLL_W-1:0] long_polls;
	} cfg_t;

endpackage

>>> design/bdpc_core.sv
// Debounce and press classification state, updated once per accepted beat.
// Depends on bdpc_pkg and the assertion macro header.
`include "button_debounce_press_classifier_defines.svh"

module bdpc_core
	import bdpc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   step,
	input  logic   pin_level,
	input  logic   start_accepted,
	output event_t event_next
);

	localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

	logic                previous_raw_q;
	logic                stable_level_q;
	logic [SAMPLE_W-1:0] same_count_q;
	logic [HOLD_W-1:0]   hold_count_q;
	logic                long_trig_q;
	logic                long_acc_q;

	logic                previous_raw_d;
	logic                stable_level_d;
	logic [SAMPLE_W-1:0] same_count_d;
	logic [HOLD_W-1:0]   hold_count_d;
	logic                long_trig_d;
	logic                long_acc_d;
	logic [HOLD_W-1:0]   hold_inc;
	logic [SAMPLE_W-1:0] cnt;
	logic                hold_reached;

	always_comb begin
		hold_inc = hold_count_q;
		if (!stable_level_q && hold_count_q != HOLD_MAX) begin
			hold_inc = hold_count_q + 1'b1;
		end
		hold_reached = CMP_W'(hold_inc) >= CMP_W'(cfg.long_polls);

		cnt = same_count_q;
		if (same_count_q < cfg.stable_polls) begin
			cnt = same_count_q + 1'b1;
		end

		previous_raw_d = previous_raw_q;
		stable_level_d = stable_level_q;
		same_count_d = same_count_q;
		hold_count_d = hold_inc;
		long_trig_d = long_trig_q;
		long_acc_d = long_acc_q;
		event_next = EV_NONE;

		if (pin_level != previous_raw_q) begin
			previous_raw_d = pin_level;
			same_count_d = SAMPLE_W'(1);
		end else begin
			same_count_d = cnt;
			if (cnt >= cfg.stable_polls) begin
				if (pin_level != stable_level_q) begin
					stable_level_d = pin_level;
					long_trig_d = 1'b0;
					long_acc_d = 1'b0;
					if (!pin_level) begin
						hold_count_d = '0;
					end else if (long_trig_q) begin
						event_next = long_acc_q ? EV_LONG_END : EV_NONE;
					end else begin
						event_next = EV_SHORT;
					end
				end else if (!stable_level_q && !long_trig_q && hold_reached) begin
					long_trig_d = 1'b1;
					long_acc_d = start_accepted;
					event_next = EV_LONG_START;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_raw_q <= 1'b1;
			stable_level_q <= 1'b1;
			same_count_q <= '0;
			hold_count_q <= '0;
			long_trig_q <= 1'b0;
			long_acc_q <= 1'b0;
		end else if (step) begin
			previous_raw_q <= previous_raw_d;
			stable_level_q <= stable_level_d;
			same_count_q <= same_count_d;
			hold_count_q <= hold_count_d;
			long_trig_q <= long_trig_d;
			long_acc_q <= long_acc_d;
		end
	end

	// An accepted long press always belongs to a started long press.
	`BDPC_ASSERT_ALWAYS(a_acc_needs_trig, !long_acc_q || long_trig_q)
	// A long press can only be in progress while the button is held.
	`BDPC_ASSERT_ALWAYS(a_trig_while_pressed, !stable_level_q || !long_trig_q)
	`BDPC_ASSERT_NEXT(a_start_sets_trig, step && event_next == EV_LONG_START, long_trig_q)

endmodule

>>> design/button_debounce_press_classifier.sv
// Button debounce and short/long press classifier, top level.
// Output: each result is registered, in the skid register first while the output is stalled.
// Throughput: one beat per cycle while item_stall is low; a two-entry output buffer keeps
// input open for one more beat while a result is stalled. Configuration writes are always ready.
// Reset: asynchronous, active low; registers return to 3 and 25 polls, button released.
// Depends on bdpc_pkg, bdpc_core and the assertion macro header.
`include "button_debounce_press_classifier_defines.svh"

module button_debounce_press_classifier
	import bdpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 pin_level,
	input  logic                 start_accepted,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [1:0]           event_res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [POLL_W-1:0]    cfg_data
);

	cfg_t   cfg_q;
	event_t event_next;
	event_t out_ev_q;
	event_t skid_ev_q;
	logic   out_valid_q;
	logic   skid_valid_q;
	logic   accept;
	logic   out_move;

	assign cfg_ready = 1'b1;
	assign item_stall = skid_valid_q;
	assign accept = item_valid && !skid_valid_q;
	assign out_move = out_valid_q && !res_stall;
	assign res_valid = out_valid_q;
	assign event_res = out_ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stable_polls <= SAMPLE_W'(3);
			cfg_q.long_polls <= POLL_W'(25);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STABLE_POLLS: cfg_q.stable_polls <= cfg_data[SAMPLE_W-1:0];
				REG_LONG_POLLS:   cfg_q.long_polls <= cfg_data;
				default: ;
			endcase
		end
	end

	bdpc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.step           (accept),
		.pin_level      (pin_level),
		.start_accepted (start_accepted),
		.event_next     (event_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_move) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept && out_valid_q && !out_move) begin
				skid_valid_q <= 1'b1;
			end
			if (!out_valid_q || out_move) begin
				out_valid_q <= skid_valid_q || accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_move) begin
			if (skid_valid_q) begin
				out_ev_q <= skid_ev_q;
			end else if (accept) begin
				out_ev_q <= event_next;
			end
		end
		if (accept && out_valid_q && !out_move) begin
			skid_ev_q <= event_next;
		end
	end

	`BDPC_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q)
	`BDPC_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_q)
	`BDPC_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_move, !skid_valid_q)

endmodule
